/* rtl/s5rp_pkg.sv */
// Shared types, codes and helper functions for the SOCKS5 request parser.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none
package s5rp_pkg;

  typedef enum logic [2:0] {
    PH_VER  = 3'd0,
    PH_CMD  = 3'd1,
    PH_RSV  = 3'd2,
    PH_ATYP = 3'd3,
    PH_DLEN = 3'd4,
    PH_ADDR = 3'd5,
    PH_PORT = 3'd6,
    PH_IDLE = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_CMD  = 2'd0;
  localparam logic [1:0] ERR_RSV  = 2'd1;
  localparam logic [1:0] ERR_ATYP = 2'd2;

  localparam logic [2:0] ATYP_NONE   = 3'd0;
  localparam logic [2:0] ATYP_IPV4   = 3'd1;
  localparam logic [2:0] ATYP_DOMAIN = 3'd3;
  localparam logic [2:0] ATYP_IPV6   = 3'd4;

  localparam logic [7:0] IPV4_TEXT_LEN = 8'd15;  // 4 groups of 3 digits, 3 dots
  localparam logic [7:0] IPV6_TEXT_LEN = 8'd39;  // 16 hex pairs, 7 colons
  localparam logic [7:0] CMD_MAX       = 8'd3;
  localparam logic [7:0] ATYP_MAX      = 8'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // One queue entry: every result caused by one request byte
  typedef struct packed {
    logic [2:0]      n;        // results in the group, 1 to 4
    logic [1:0]      kind;
    logic [3:0][7:0] chars;    // chars[0] goes out first
    logic [1:0]      err;
    logic [7:0]      version;
    logic [1:0]      command;
    logic [2:0]      atyp;
    logic [7:0]      addr_len;
    logic [15:0]     port;
  } group_t;

  // Three decimal ASCII digits of a byte, hundreds in [0]
  function automatic logic [2:0][7:0] dec_chars(input logic [7:0] b);
    logic [1:0]  h;
    logic [7:0]  r8;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [7:0]  t10;
    logic [7:0]  o;
    logic [2:0][7:0] res;
    if (b >= 8'd200) begin
      h  = 2'd2;
      r8 = b - 8'd200;
    end else if (b >= 8'd100) begin
      h  = 2'd1;
      r8 = b - 8'd100;
    end else begin
      h  = 2'd0;
      r8 = b;
    end
    r    = r8[6:0];
    // r / 10 by reciprocal, exact below 1029
    prod = 15'({8'd0, r} * 15'd205);
    t    = prod[14:11];
    t10  = 8'({4'd0, t} * 8'd10);
    o    = 8'({1'b0, r}) - t10;
    res[0] = CHAR_ZERO + {6'd0, h};
    res[1] = CHAR_ZERO + {4'd0, t};
    res[2] = CHAR_ZERO + o;
    return res;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = CHAR_ZERO + {4'd0, v};
    else           c = CHAR_A + {4'd0, v} - 8'd10;
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/s5rp_front.sv */
// Front part: accepts request bytes, runs the field parser and builds at most one
// result group per byte. Depends on s5rp_pkg.
`default_nettype none
module s5rp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_op,
  input  wire logic [7:0]      in_byte,
  output s5rp_pkg::group_t     grp,
  output logic                 push
);

  s5rp_pkg::phase_t phase, phase_next;
  logic [7:0]  ver_reg, ver_reg_next;
  logic [1:0]  cmd_reg, cmd_reg_next;
  logic [2:0]  atype_reg, atype_reg_next;
  logic [7:0]  text_size, text_size_next;
  logic [7:0]  text_index, text_index_next;
  logic [7:0]  addr_bytes_seen, addr_bytes_seen_next;
  logic [15:0] port_acc, port_acc_next;
  logic [1:0]  port_bytes_seen, port_bytes_seen_next;

  logic [2:0][7:0] dec;
  logic [7:0]      seen_inc;
  logic [7:0]      idx_plus2;
  logic [7:0]      idx_plus3;
  logic [2:0]      n;
  logic [1:0]      kind;
  logic [1:0]      err;
  logic [3:0][7:0] chars;

  assign dec       = s5rp_pkg::dec_chars(in_byte);
  assign seen_inc  = addr_bytes_seen + 8'd1;
  assign idx_plus2 = text_index + 8'd2;
  assign idx_plus3 = text_index + 8'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= s5rp_pkg::PH_VER;
      ver_reg         <= '0;
      cmd_reg         <= '0;
      atype_reg       <= '0;
      text_size       <= '0;
      text_index      <= '0;
      addr_bytes_seen <= '0;
      port_acc        <= '0;
      port_bytes_seen <= '0;
    end else begin
      phase           <= phase_next;
      ver_reg         <= ver_reg_next;
      cmd_reg         <= cmd_reg_next;
      atype_reg       <= atype_reg_next;
      text_size       <= text_size_next;
      text_index      <= text_index_next;
      addr_bytes_seen <= addr_bytes_seen_next;
      port_acc        <= port_acc_next;
      port_bytes_seen <= port_bytes_seen_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    ver_reg_next         = ver_reg;
    cmd_reg_next         = cmd_reg;
    atype_reg_next       = atype_reg;
    text_size_next       = text_size;
    text_index_next      = text_index;
    addr_bytes_seen_next = addr_bytes_seen;
    port_acc_next        = port_acc;
    port_bytes_seen_next = port_bytes_seen;
    n     = 3'd0;
    kind  = s5rp_pkg::KIND_CHAR;
    err   = '0;
    chars = '0;

    if (in_valid) begin
      if (in_op) begin
        phase_next           = s5rp_pkg::PH_VER;
        ver_reg_next         = '0;
        cmd_reg_next         = '0;
        atype_reg_next       = '0;
        text_size_next       = '0;
        text_index_next      = '0;
        addr_bytes_seen_next = '0;
        port_acc_next        = '0;
        port_bytes_seen_next = '0;
      end else begin
        case (phase)
          s5rp_pkg::PH_VER: begin
            ver_reg_next = in_byte;
            phase_next   = s5rp_pkg::PH_CMD;
          end
          s5rp_pkg::PH_CMD: begin
            if (in_byte > s5rp_pkg::CMD_MAX) begin
              n          = 3'd1;
              kind       = s5rp_pkg::KIND_ERR;
              err        = s5rp_pkg::ERR_CMD;
              phase_next = s5rp_pkg::PH_IDLE;
            end else begin
              cmd_reg_next = in_byte[1:0];
              phase_next   = s5rp_pkg::PH_RSV;
            end
          end
          s5rp_pkg::PH_RSV: begin
            if (in_byte != 8'd0) begin
              n          = 3'd1;
              kind       = s5rp_pkg::KIND_ERR;
              err        = s5rp_pkg::ERR_RSV;
              phase_next = s5rp_pkg::PH_IDLE;
            end else begin
              phase_next = s5rp_pkg::PH_ATYP;
            end
          end
          s5rp_pkg::PH_ATYP: begin
            if (in_byte == 8'd2 || in_byte > s5rp_pkg::ATYP_MAX) begin
              n          = 3'd1;
              kind       = s5rp_pkg::KIND_ERR;
              err        = s5rp_pkg::ERR_ATYP;
              phase_next = s5rp_pkg::PH_IDLE;
            end else begin
              atype_reg_next       = in_byte[2:0];
              text_index_next      = '0;
              addr_bytes_seen_next = '0;
              port_bytes_seen_next = '0;
              case (in_byte[2:0])
                s5rp_pkg::ATYP_IPV4: begin
                  text_size_next = s5rp_pkg::IPV4_TEXT_LEN;
                  phase_next     = s5rp_pkg::PH_ADDR;
                end
                s5rp_pkg::ATYP_IPV6: begin
                  text_size_next = s5rp_pkg::IPV6_TEXT_LEN;
                  phase_next     = s5rp_pkg::PH_ADDR;
                end
                s5rp_pkg::ATYP_DOMAIN: begin
                  phase_next = s5rp_pkg::PH_DLEN;
                end
                default: begin
                  text_size_next = '0;
                  phase_next     = s5rp_pkg::PH_PORT;
                end
              endcase
            end
          end
          s5rp_pkg::PH_DLEN: begin
            text_size_next = in_byte;
            phase_next     = (in_byte != 8'd0) ? s5rp_pkg::PH_ADDR : s5rp_pkg::PH_PORT;
          end
          s5rp_pkg::PH_ADDR: begin
            addr_bytes_seen_next = seen_inc;
            if (atype_reg == s5rp_pkg::ATYP_IPV4) begin
              chars[0] = dec[0];
              chars[1] = dec[1];
              chars[2] = dec[2];
              if (idx_plus3 < text_size) begin
                chars[3] = s5rp_pkg::CHAR_DOT;
                n        = 3'd4;
              end else begin
                n        = 3'd3;
              end
            end else if (atype_reg == s5rp_pkg::ATYP_IPV6) begin
              chars[0] = s5rp_pkg::hex_char(in_byte[7:4]);
              chars[1] = s5rp_pkg::hex_char(in_byte[3:0]);
              // colon after every second byte, never after the last
              if (!seen_inc[0] && idx_plus2 < text_size) begin
                chars[2] = s5rp_pkg::CHAR_COLON;
                n        = 3'd3;
              end else begin
                n        = 3'd2;
              end
            end else begin
              chars[0] = in_byte;
              n        = 3'd1;
            end
            text_index_next = text_index + {5'd0, n};
            if (text_index_next >= text_size) begin
              phase_next           = s5rp_pkg::PH_PORT;
              port_bytes_seen_next = '0;
            end
          end
          s5rp_pkg::PH_PORT: begin
            port_acc_next        = {port_acc[7:0], in_byte};
            port_bytes_seen_next = port_bytes_seen + 2'd1;
            if (port_bytes_seen_next >= 2'd2) begin
              n          = 3'd1;
              kind       = s5rp_pkg::KIND_DONE;
              phase_next = s5rp_pkg::PH_IDLE;
            end
          end
          default: begin
            // idle: drop bytes until the next start
          end
        endcase
      end
    end

    push          = (n != 3'd0);
    grp.n         = n;
    grp.kind      = kind;
    grp.chars     = chars;
    grp.err       = err;
    grp.version   = ver_reg_next;
    grp.command   = cmd_reg_next;
    grp.atyp      = atype_reg_next;
    grp.addr_len  = text_index_next;
    grp.port      = port_acc_next;
  end

endmodule
`default_nettype wire

/* rtl/s5rp_queue.sv */
// Small queue of result groups between the parser and the serialiser.
// Depends on s5rp_pkg for the entry type.
`default_nettype none
module s5rp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire s5rp_pkg::group_t wr_data,
  output logic                  not_full,
  input  wire logic             rd_en,
  output s5rp_pkg::group_t      rd_data,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  s5rp_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/s5rp_back.sv */
// Back part: serialises the head result group one result per cycle into the
// output register while it is empty or being taken. Depends on s5rp_pkg.
`default_nettype none
module s5rp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire s5rp_pkg::group_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [55:0]           m_tdata,
  output logic                  m_tlast
);

  logic [1:0]  sub;
  logic [1:0]  sub_next;
  logic        load;
  logic        is_last;
  logic [55:0] word;

  assign load    = head_valid && (!m_tvalid || m_tready);
  assign is_last = ({1'b0, sub} == head.n - 3'd1);
  assign pop     = load && is_last;
  assign sub_next = is_last ? 2'd0 : sub + 2'd1;

  assign word = {7'd0, head.port, head.addr_len, head.atyp, head.command,
                 head.version, head.err, head.chars[sub], head.kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sub      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sub      <= sub_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= word;
      m_tlast <= is_last;
    end
  end

endmodule
`default_nettype wire

/* rtl/socks5_request_parser_unit.sv */
// SOCKS5 request parser: bytes in, address text, done and error items out.
// Path: a byte's results go into the group queue, then one at a time into the output register.
// Throughput: one input transfer per cycle while the group queue has room; results
// leave one per cycle while the output is not stalled, each character of an address byte as its own result.
// Reset: rst clears parser state, queue and output valid; a start op clears parser state only.
// Depends on s5rp_pkg, s5rp_front, s5rp_queue and s5rp_back.
`default_nettype none
module socks5_request_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [1:0] kind, [9:2] char_value, [11:10] err_code,
                                      // [19:12] version, [21:20] command, [24:22] atyp,
                                      // [32:25] addr_len, [48:33] port, [55:49] zero
  output logic             m_tlast
);

  s5rp_pkg::group_t grp;
  s5rp_pkg::group_t head;
  logic push;
  logic not_full;
  logic not_empty;
  logic pop;

  assign s_tready = not_full;

  s5rp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid && not_full),
    .in_op    (s_tuser),
    .in_byte  (s_tdata),
    .grp      (grp),
    .push     (push)
  );

  s5rp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_data   (grp),
    .not_full  (not_full),
    .rd_en     (pop),
    .rd_data   (head),
    .not_empty (not_empty)
  );

  s5rp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
